// ===== src/connection_flow_table_core_defines.svh =====
// ---------------------------------------------------------------------------
// Connection flow table assertion macros
// Shared concurrent check forms, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef CONNECTION_FLOW_TABLE_CORE_DEFINES_SVH
`define CONNECTION_FLOW_TABLE_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define CFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen outside reset
`define CFT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== src/cft_pkg.sv =====
// ---------------------------------------------------------------------------
// Connection flow table package
// Operation, status and register codes, sequencer states and defaults.
// ---------------------------------------------------------------------------
package cft_pkg;

  // Parameter defaults
  localparam int MAX_ENTRIES_DEF  = 512;
  localparam int HOST_ID_BITS_DEF = 32;
  localparam int APP_ID_BITS_DEF  = 16;

  // Fixed field widths
  localparam int HANDLE_W    = 16;
  localparam int COUNT_OUT_W = 10;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_DEL     = 2'd1,
    OP_INGRESS = 2'd2,
    OP_RSVD    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_EXACT      = 3'd0,
    ST_WRONG_HOST = 3'd1,
    ST_NO_MATCH   = 3'd2,
    ST_WILDCARD   = 3'd3,
    ST_ADDED      = 3'd4,
    ST_DELETED    = 3'd5,
    ST_DEL_MISS   = 3'd6,
    ST_FULL       = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_MODE    = 4'd0,
    CFG_MY_HOST_ID    = 4'd1,
    CFG_WILDCARD_APP  = 4'd2,
    CFG_WILDCARD_HOST = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } state_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   handle;
  } res_t;

endpackage

// ===== src/cft_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/cft_match.sv =====
// ---------------------------------------------------------------------------
// Connection flow table entry comparator
// Compares one stored entry with a search key; remote ids only when asked.
// ---------------------------------------------------------------------------
module cft_match
  import cft_pkg::*;
#(
  parameter int HOST_ID_BITS = HOST_ID_BITS_DEF,
  parameter int APP_ID_BITS  = APP_ID_BITS_DEF
) (
  input  logic [APP_ID_BITS-1:0]  ent_loc,
  input  logic [APP_ID_BITS-1:0]  ent_rapp,
  input  logic [HOST_ID_BITS-1:0] ent_rhost,
  input  logic [APP_ID_BITS-1:0]  key_loc,
  input  logic [APP_ID_BITS-1:0]  key_rapp,
  input  logic [HOST_ID_BITS-1:0] key_rhost,
  input  logic                    full_cmp,
  output logic                    hit
);

  logic loc_eq;
  logic rem_eq;

  // Local id always decides; remote pair only in full compare
  assign loc_eq = (ent_loc == key_loc);
  assign rem_eq = (ent_rapp == key_rapp) && (ent_rhost == key_rhost);
  assign hit    = loc_eq && (!full_cmp || rem_eq);

endmodule

// ===== src/cft_ctrl.sv =====
// ---------------------------------------------------------------------------
// Connection flow table sequencer
// Runs add, delete and ingress lookup over the entry RAM, one entry a cycle
// through the shared comparator.
// ---------------------------------------------------------------------------
module cft_ctrl
  import cft_pkg::*;
#(
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int HOST_ID_BITS = HOST_ID_BITS_DEF,
  parameter int APP_ID_BITS  = APP_ID_BITS_DEF,
  localparam int IW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int EW = 2 * APP_ID_BITS + HOST_ID_BITS + HANDLE_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // item in
  input  logic                    item_vld,
  input  op_t                     item_op,
  input  logic [APP_ID_BITS-1:0]  item_loc,
  input  logic [APP_ID_BITS-1:0]  item_rapp,
  input  logic [HOST_ID_BITS-1:0] item_rhost,
  input  logic [HOST_ID_BITS-1:0] item_dhost,
  input  logic [HANDLE_W-1:0]     item_hdl,
  output logic                    idle,
  // configuration
  input  logic                    match_mode,
  input  logic [HOST_ID_BITS-1:0] my_host,
  input  logic [APP_ID_BITS-1:0]  wc_app,
  input  logic [HOST_ID_BITS-1:0] wc_host,
  // result
  input  logic                    out_free,
  output logic                    res_vld,
  output res_t                    res,
  output logic [CW-1:0]           cnt,
  // entry RAM
  output logic                    ram_wr_en,
  output logic [IW-1:0]           ram_wr_addr,
  output logic [EW-1:0]           ram_wr_data,
  output logic [IW-1:0]           ram_rd_addr,
  input  logic [EW-1:0]           ram_rd_data
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [APP_ID_BITS-1:0]  loc_r, loc_nxt;
  logic [APP_ID_BITS-1:0]  rapp_r, rapp_nxt;
  logic [HOST_ID_BITS-1:0] rhost_r, rhost_nxt;
  logic [HOST_ID_BITS-1:0] dhost_r, dhost_nxt;
  logic [HANDLE_W-1:0]     hdl_r, hdl_nxt;
  logic                    wild_r, wild_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]           hit_idx_r, hit_idx_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  status_t                 status_r, status_nxt;
  logic [HANDLE_W-1:0]     handle_r, handle_nxt;

  logic [APP_ID_BITS-1:0]  ent_loc, ent_rapp, key_rapp;
  logic [HOST_ID_BITS-1:0] ent_rhost, key_rhost;
  logic [HANDLE_W-1:0]     ent_hdl;
  logic [CW-1:0]           last_idx;
  logic                    full_cmp, hit_raw, hit, issue, scan_miss;

  // Unpack the entry read last cycle
  assign ent_loc   = ram_rd_data[APP_ID_BITS-1:0];
  assign ent_rapp  = ram_rd_data[2*APP_ID_BITS-1:APP_ID_BITS];
  assign ent_rhost = ram_rd_data[2*APP_ID_BITS+HOST_ID_BITS-1:2*APP_ID_BITS];
  assign ent_hdl   = ram_rd_data[EW-1:2*APP_ID_BITS+HOST_ID_BITS];

  // Key select: exact key or wildcard listener
  assign key_rapp  = wild_r ? wc_app  : rapp_r;
  assign key_rhost = wild_r ? wc_host : rhost_r;
  assign full_cmp  = wild_r || match_mode;

  cft_match #(
    .HOST_ID_BITS (HOST_ID_BITS),
    .APP_ID_BITS  (APP_ID_BITS)
  ) u_match (
    .ent_loc   (ent_loc),
    .ent_rapp  (ent_rapp),
    .ent_rhost (ent_rhost),
    .key_loc   (loc_r),
    .key_rapp  (key_rapp),
    .key_rhost (key_rhost),
    .full_cmp  (full_cmp),
    .hit       (hit_raw)
  );

  // Scan bookkeeping: one read issued and one entry compared per cycle
  assign hit       = cmp_vld_r && hit_raw;
  assign issue     = !hit && (ptr_r < count_r);
  assign scan_miss = !hit && !issue && !cmp_vld_r;
  assign last_idx  = count_r - CW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (item_vld) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (op_r)
          OP_DEL:     state_nxt = S_SCAN;
          OP_INGRESS: state_nxt = (dhost_r == my_host) ? S_SCAN : S_DONE;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (op_r == OP_DEL) ? S_DEL_RD : S_DONE;
        end else if (scan_miss) begin
          if (!(op_r == OP_INGRESS && match_mode && !wild_r)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DEL_RD: state_nxt = S_DEL_WR;
      S_DEL_WR: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_nxt      = op_r;
    loc_nxt     = loc_r;
    rapp_nxt    = rapp_r;
    rhost_nxt   = rhost_r;
    dhost_nxt   = dhost_r;
    hdl_nxt     = hdl_r;
    wild_nxt    = wild_r;
    ptr_nxt     = ptr_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    hit_idx_nxt = hit_idx_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    handle_nxt  = handle_r;
    idle        = 1'b0;
    res_vld     = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[IW-1:0];
    ram_wr_data = {hdl_r, rhost_r, rapp_r, loc_r};
    ram_rd_addr = ptr_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        // Capture the accepted item
        if (item_vld) begin
          op_nxt    = item_op;
          loc_nxt   = item_loc;
          rapp_nxt  = item_rapp;
          rhost_nxt = item_rhost;
          dhost_nxt = item_dhost;
          hdl_nxt   = item_hdl;
        end
      end
      S_DISPATCH: begin
        wild_nxt   = 1'b0;
        ptr_nxt    = '0;
        handle_nxt = '0;
        status_nxt = ST_NO_MATCH;
        unique case (op_r)
          OP_ADD: begin
            // Append at the end unless full
            if (count_r == MAX_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              ram_wr_en  = 1'b1;
              count_nxt  = count_r + CW'(1);
              status_nxt = ST_ADDED;
            end
          end
          OP_INGRESS: begin
            if (dhost_r != my_host) begin
              status_nxt = ST_WRONG_HOST;
            end
          end
          default: status_nxt = ST_NO_MATCH;
        endcase
      end
      S_SCAN: begin
        if (issue) begin
          ptr_nxt     = ptr_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ptr_r[IW-1:0];
        end
        if (hit) begin
          hit_idx_nxt = cmp_idx_r;
          if (op_r != OP_DEL) begin
            handle_nxt = ent_hdl;
            status_nxt = wild_r ? ST_WILDCARD : ST_EXACT;
          end
        end else if (scan_miss) begin
          priority if (op_r == OP_DEL) begin
            status_nxt = ST_DEL_MISS;
          end else if (match_mode && !wild_r) begin
            // Restart the pass for a wildcard listener
            wild_nxt = 1'b1;
            ptr_nxt  = '0;
          end else begin
            status_nxt = ST_NO_MATCH;
          end
        end
      end
      S_DEL_RD: begin
        // Fetch the last entry to fill the hole
        ram_rd_addr = last_idx[IW-1:0];
      end
      S_DEL_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = hit_idx_r;
        ram_wr_data = ram_rd_data;
        count_nxt   = last_idx;
        status_nxt  = ST_DELETED;
        handle_nxt  = '0;
      end
      S_DONE: begin
        res_vld = out_free;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.handle = handle_r;
  assign cnt        = count_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      wild_r    <= 1'b0;
      ptr_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      wild_r    <= wild_nxt;
      ptr_r     <= ptr_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    loc_r     <= loc_nxt;
    rapp_r    <= rapp_nxt;
    rhost_r   <= rhost_nxt;
    dhost_r   <= dhost_nxt;
    hdl_r     <= hdl_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    status_r  <= status_nxt;
    handle_r  <= handle_nxt;
  end

endmodule

// ===== src/connection_flow_table_core.sv =====
// ---------------------------------------------------------------------------
// Connection flow table core
// Linear-scan connection table: add, delete and ingress lookup.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transfer; in_tuser is the operation code,
//           in_tdata the ids and the handle to store.
//   out_* : one result per operation; out_tuser is the status, out_tdata
//           the matched handle and the entry count after the operation.
//   cfg_* : register writes, always taken; write only while idle.
// Sequence: add, reserved code and wrong host go from dispatch straight to
//   the result; a lookup or delete scans the entries in order, and a delete
//   hit then fetches the tail into the hole; a lookup miss in full compare
//   mode rescans for the wildcard listener. One entry is compared a cycle
//   through the RAM read port and the shared comparator; in_tready is high only while the sequencer idles.
// Reset: entry count cleared, full compare mode, other config registers cleared;
//   the entry RAM needs no clearing pass.
// Stall: a result waits in the output register while out_tready is low;
//   the next operation may be taken meanwhile and parks at its result.
// ---------------------------------------------------------------------------
`include "connection_flow_table_core_defines.svh"

module connection_flow_table_core
  import cft_pkg::*;
#(
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
  parameter int HOST_ID_BITS = HOST_ID_BITS_DEF,
  parameter int APP_ID_BITS  = APP_ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tuser: operation[1:0]
  // in_tdata: local_app[15:0], peer_app[31:16], peer_host[63:32],
  //           dest_host_id[95:64], conn_handle_in[111:96]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [111:0]          in_tdata,
  input  logic [1:0]            in_tuser,
  // out_tuser: status[2:0]
  // out_tdata: conn_handle_out[15:0], entry_count[25:16], zero[31:26]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,
  output logic [2:0]            out_tuser,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = APP_ID_BITS;
  localparam int HW = HOST_ID_BITS;
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = 2 * AW + HW + HANDLE_W;

  // Configuration registers
  logic        match_mode_r;
  logic [31:0] my_host_r;
  logic [15:0] wc_app_r;
  logic [31:0] wc_host_r;

  // Id fields fitted to the configured widths
  logic [AW+15:0] loc_ext, rapp_ext, wca_ext;
  logic [HW+31:0] rhost_ext, dhost_ext, myh_ext, wch_ext;
  logic [CW+COUNT_OUT_W-1:0] cnt_ext;

  logic                ctrl_idle, res_vld, out_free;
  res_t                res;
  logic [CW-1:0]       cnt;
  logic                ram_wr_en;
  logic [IW-1:0]       ram_wr_addr, ram_rd_addr;
  logic [EW-1:0]       ram_wr_data, ram_rd_data;

  logic                out_tvalid_r;
  logic [2:0]          out_tuser_r;
  logic [31:0]         out_tdata_r;

  assign loc_ext   = {{AW{1'b0}}, in_tdata[15:0]};
  assign rapp_ext  = {{AW{1'b0}}, in_tdata[31:16]};
  assign wca_ext   = {{AW{1'b0}}, wc_app_r};
  assign rhost_ext = {{HW{1'b0}}, in_tdata[63:32]};
  assign dhost_ext = {{HW{1'b0}}, in_tdata[95:64]};
  assign myh_ext   = {{HW{1'b0}}, my_host_r};
  assign wch_ext   = {{HW{1'b0}}, wc_host_r};
  assign cnt_ext   = {{COUNT_OUT_W{1'b0}}, cnt};

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_mode_r <= 1'b1;
      my_host_r    <= '0;
      wc_app_r     <= '0;
      wc_host_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MATCH_MODE:    match_mode_r <= cfg_data[0];
        CFG_MY_HOST_ID:    my_host_r    <= cfg_data;
        CFG_WILDCARD_APP:  wc_app_r     <= cfg_data[15:0];
        CFG_WILDCARD_HOST: wc_host_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = ctrl_idle;

  cft_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  cft_ctrl #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .HOST_ID_BITS (HOST_ID_BITS),
    .APP_ID_BITS  (APP_ID_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (in_tvalid && in_tready),
    .item_op     (op_t'(in_tuser)),
    .item_loc    (loc_ext[AW-1:0]),
    .item_rapp   (rapp_ext[AW-1:0]),
    .item_rhost  (rhost_ext[HW-1:0]),
    .item_dhost  (dhost_ext[HW-1:0]),
    .item_hdl    (in_tdata[111:96]),
    .idle        (ctrl_idle),
    .match_mode  (match_mode_r),
    .my_host     (myh_ext[HW-1:0]),
    .wc_app      (wca_ext[AW-1:0]),
    .wc_host     (wch_ext[HW-1:0]),
    .out_free    (out_free),
    .res_vld     (res_vld),
    .res         (res),
    .cnt         (cnt),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Output register: load a result when empty or draining, drop on transfer
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_vld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_tuser_r <= res.status;
      out_tdata_r <= {6'd0, cnt_ext[COUNT_OUT_W-1:0], res.handle};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  `CFT_NEVER(a_count_bound, cnt > CW'(MAX_ENTRIES), "entry count beyond table size")
  `CFT_ASSERT(a_busy_after_take, (in_tvalid && in_tready) |=> !in_tready, "took two items")
  `CFT_ASSERT(a_no_overwrite, res_vld |-> out_free, "result overwrote pending output")

endmodule
